[design/kwmpq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kwmpq_pkg
// Shared types and codes for the K-way merge priority queue cell chain.
// ----------------------------------------------------------------------------
package kwmpq_pkg;

    localparam int VALUE_W = 32;
    localparam int LIST_W  = 4;
    localparam int KEY_W   = VALUE_W + LIST_W;

    localparam logic FUNC_INSERT  = 1'b0;
    localparam logic FUNC_EXTRACT = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef logic [KEY_W-1:0] t_key;

    typedef struct packed {
        logic valid;
        t_key key;
    } t_slot;

    typedef struct packed {
        t_slot slot;
        logic  gt;
    } t_link;

    typedef struct packed {
        logic ins;
        logic ext;
        t_key key;
    } t_op;

endpackage : kwmpq_pkg
`default_nettype wire

[design/k_way_merge_priority_queue.sv]
// Execution: a word accepted into the command register is executed by the cell
// chain in the cycle after the accept, and its result is registered by the same edge.
// Acceptance: no word is taken while the command register holds the single insert
// or extract it hands to the cell chain or a result waits; independent of NUM_LISTS.
// Reset: synchronous active-low i_rst_n empties the chain and drops any word.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// k_way_merge_priority_queue
// Min-priority queue for a K-way merge, built as a sorted chain of cells.
// ----------------------------------------------------------------------------
module k_way_merge_priority_queue #(
    parameter int NUM_LISTS = 16
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_valid,
    output logic                                  o_ready,
    input  wire                                   i_func,
    input  wire signed [kwmpq_pkg::VALUE_W-1:0]   i_value,
    input  wire        [kwmpq_pkg::LIST_W-1:0]    i_list_index,
    output logic                                  o_valid,
    input  wire                                   i_ready,
    output logic signed [kwmpq_pkg::VALUE_W-1:0]  o_out_value,
    output logic        [kwmpq_pkg::LIST_W-1:0]   o_out_list,
    output logic        [1:0]                     o_status
);
    import kwmpq_pkg::*;

    logic r_cmd_vld;
    logic r_cmd_func;
    t_key r_cmd_key;
    logic r_out_vld;

    t_link            links [0:NUM_LISTS];
    t_slot            slots [0:NUM_LISTS];
    logic [NUM_LISTS-1:0] valid_vec;
    t_op              op;
    logic             empty;
    logic             full;
    logic             accept;

    assign links[0].slot.valid = 1'b1;
    assign links[0].slot.key   = '0;
    assign links[0].gt         = 1'b0;
    assign slots[NUM_LISTS]    = '0;

    genvar gi;
    generate
        for (gi = 0; gi < NUM_LISTS; gi++) begin : g_cell
            kwmpq_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_op    (op),
                .i_left  (links[gi]),
                .i_right (slots[gi+1]),
                .o_right (links[gi+1]),
                .o_left  (slots[gi])
            );
            assign valid_vec[gi] = links[gi+1].slot.valid;
        end
    endgenerate

    assign empty = !valid_vec[0];
    assign full  = valid_vec[NUM_LISTS-1];

    assign op.ins = r_cmd_vld && (r_cmd_func == FUNC_INSERT) && !full;
    assign op.ext = r_cmd_vld && (r_cmd_func == FUNC_EXTRACT) && !empty;
    assign op.key = r_cmd_key;

    assign o_ready = !r_cmd_vld && (!r_out_vld || i_ready);
    assign accept  = i_valid && o_ready;
    assign o_valid = r_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_cmd_vld <= accept;
            if (r_cmd_vld) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
        if (accept) begin
            r_cmd_func <= i_func;
            r_cmd_key  <= {~i_value[VALUE_W-1], i_value[VALUE_W-2:0], i_list_index};
        end
        if (r_cmd_vld) begin
            o_out_value <= '0;
            o_out_list  <= '0;
            o_status    <= ST_OK;
            if (r_cmd_func == FUNC_EXTRACT) begin
                if (empty) begin
                    o_status <= ST_EMPTY;
                end else begin
                    o_out_value <= {~slots[0].key[KEY_W-1], slots[0].key[KEY_W-2:LIST_W]};
                    o_out_list  <= slots[0].key[LIST_W-1:0];
                end
            end else if (full) begin
                o_status <= ST_FULL;
            end
        end
    end

`ifndef SYNTHESIS
    a_thermometer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (valid_vec[NUM_LISTS-1:1] & ~valid_vec[NUM_LISTS-2:0]) == '0)
        else $error("chain occupancy is not contiguous");

    a_head_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        valid_vec[1] |-> (slots[0].key <= slots[1].key))
        else $error("chain head is not the smallest key");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmd_vld |=> o_valid)
        else $error("executed word produced no result");

    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ST_OK)) |-> (o_out_value == '0 && o_out_list == '0))
        else $error("error status with nonzero payload");
`endif

endmodule : k_way_merge_priority_queue
`default_nettype wire

[design/kwmpq_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kwmpq_cell
// One slot of the sorted chain: holds a key, shifts right on insert,
// shifts left on extract.
// ----------------------------------------------------------------------------
module kwmpq_cell (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  kwmpq_pkg::t_op      i_op,
    input  kwmpq_pkg::t_link    i_left,
    input  kwmpq_pkg::t_slot    i_right,
    output kwmpq_pkg::t_link    o_right,
    output kwmpq_pkg::t_slot    o_left
);
    import kwmpq_pkg::*;

    logic r_valid;
    t_key r_key;
    logic n_valid;
    t_key n_key;
    logic gt_own;

    assign gt_own = r_valid && (r_key > i_op.key);

    assign o_right.slot.valid = r_valid;
    assign o_right.slot.key   = r_key;
    assign o_right.gt         = gt_own;
    assign o_left.valid       = r_valid;
    assign o_left.key         = r_key;

    always_comb begin
        priority if (i_op.ext) begin
            n_valid = i_right.valid;
            n_key   = i_right.key;
        end else if (i_op.ins) begin
            priority if (i_left.gt) begin
                n_valid = 1'b1;
                n_key   = i_left.slot.key;
            end else if (i_left.slot.valid && (!r_valid || gt_own)) begin
                n_valid = 1'b1;
                n_key   = i_op.key;
            end else begin
                n_valid = r_valid;
                n_key   = r_key;
            end
        end else begin
            n_valid = r_valid;
            n_key   = r_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_key <= n_key;
    end

endmodule : kwmpq_cell
`default_nettype wire
